>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Operation codes of a command transfer
  typedef logic [1:0] op_t;
  localparam op_t OP_PUT   = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  // Character and attribute constants
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // One screen cell: attribute in the high byte, character in the low byte
  typedef logic [15:0] cell_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL
  } state_t;

endpackage

>>> rtl/tcw_if.sv
// Command and response channel interfaces of the text console writer.
interface tcw_cmd_if import tcw_pkg::*; ();
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, op, char_code, read_row, read_col, input ready);
  modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic       valid;
  logic       ready;
  cell_t      cell_value;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic       scrolled;

  modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

>>> rtl/text_console_writer.sv
// Text console writer: screen buffer in one memory, cursor and sweep sequencer.
//
// Usage: commands arrive on the cmd channel (put character, clear screen,
// read cell); each command gives exactly one response transfer on rsp with
// the cell read (zero unless a read), the new cursor and scroll flag. Puts
// and clears take the attribute from the text_color register, which the
// user writes via text_color_we / text_color_wdata only while idle (not enforced).
//
// Response path, from the command transfer to the response being offered:
//   put without scroll, out-of-range read, unused op: result at the same edge
//   read in range:      via S_READ (registered memory read)
//   clear:              S_FILL over every cell, one cell written per cycle
//   put that scrolls:   S_SCROLL row copy, then S_FILL of bottom row
// The sweeps are set by the single write port of the cell memory, which the
// scroll copy and the fills walk one cell per cycle. One command is worked on
// at a time; a new one is taken once the sequencer is idle and the response
// register is empty or being drained, so a stalled receiver holds off input.
//
// Reset clears the cursor, the color register (to 7) and the handshakes. The
// cell memory is not cleared: cells are undefined until the first clear.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_color_we,
  input  logic [7:0] text_color_wdata,
  tcw_cmd_if.sink    cmd,
  tcw_rsp_if.source  rsp
);

  localparam int CELLS      = ROWS * COLS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLS);
  localparam int SCROLL_LEN = (ROWS - 1) * COLS;

  // Cell memory, one write and one registered read port
  cell_t          mem [CELLS];
  cell_t          rd_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  cell_t          wr_data;

  // Control and context registers
  state_t         state, state_next;
  logic [AW-1:0]  ptr, ptr_next;
  logic [RW-1:0]  cur_row, cur_row_next;
  logic [CW-1:0]  cur_col, cur_col_next;
  logic [7:0]     text_color;
  cell_t          fill_value;
  logic           res_scrolled;

  // Combinational helpers
  logic           cmd_fire;
  logic           col_wrap;
  logic           row_last;
  logic           scroll_needed;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  read_addr;
  logic           read_ok;
  logic           out_load;
  cell_t          out_cell_next;
  logic           out_scr_next;

  assign cmd_fire = cmd.valid && cmd.ready;

  // Cursor advance for a put
  assign col_wrap      = (cmd.char_code == CH_NEWLINE) || (cur_col == CW'(COLS - 1));
  assign row_last      = (cur_row == RW'(ROWS - 1));
  assign scroll_needed = col_wrap && row_last;

  // Cell addresses
  assign cur_addr  = AW'(int'(cur_row) * COLS + int'(cur_col));
  assign read_ok   = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLS);
  assign read_addr = AW'(int'(cmd.read_row) * COLS + int'(cmd.read_col));

  // Next state, memory control and response load
  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    rd_en         = 1'b0;
    rd_addr       = ptr + AW'(COLS);
    wr_en         = 1'b0;
    wr_addr       = ptr;
    wr_data       = fill_value;
    out_load      = 1'b0;
    out_cell_next = '0;
    out_scr_next  = res_scrolled;
    cmd.ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.ready    = !rsp.valid || rsp.ready;
        out_scr_next = 1'b0;
        if (cmd_fire) begin
          unique case (cmd.op)
            OP_PUT: begin
              if (cmd.char_code != CH_NEWLINE) begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = {text_color, cmd.char_code};
              end
              if (col_wrap) begin
                cur_col_next = '0;
                if (!row_last) begin
                  cur_row_next = cur_row + 1'b1;
                end
              end else begin
                cur_col_next = cur_col + 1'b1;
              end
              if (scroll_needed) begin
                state_next = S_SCROLL;
                ptr_next   = '0;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_CLEAR: begin
              cur_row_next = '0;
              cur_col_next = '0;
              state_next   = S_FILL;
              ptr_next     = '0;
            end
            OP_READ: begin
              if (read_ok) begin
                rd_en      = 1'b1;
                rd_addr    = read_addr;
                state_next = S_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_load      = 1'b1;
        out_cell_next = rd_data;
        state_next    = S_IDLE;
      end
      S_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        if (ptr != AW'(SCROLL_LEN)) begin
          rd_en   = 1'b1;
          rd_addr = ptr + AW'(COLS);
        end
        if (ptr != '0) begin
          wr_en   = 1'b1;
          wr_addr = ptr - 1'b1;
          wr_data = rd_data;
        end
        if (ptr == AW'(SCROLL_LEN)) begin
          state_next = S_FILL;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_FILL: begin
        wr_en    = 1'b1;
        wr_addr  = ptr;
        wr_data  = fill_value;
        ptr_next = ptr + 1'b1;
        if (ptr == AW'(CELLS - 1)) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cursor, color, sweep pointer and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      text_color <= ATTR_RESET;
      rsp.valid  <= 1'b0;
      ptr        <= '0;
    end else begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      ptr     <= ptr_next;
      if (text_color_we) begin
        text_color <= text_color_wdata;
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_scrolled <= (cmd.op == OP_PUT) && scroll_needed;
      fill_value   <= (cmd.op == OP_CLEAR) ? {text_color, CH_SPACE} : {8'h00, CH_SPACE};
    end
    if (out_load) begin
      rsp.cell_value <= out_cell_next;
      rsp.cursor_row <= 5'(cur_row_next);
      rsp.cursor_col <= 7'(cur_col_next);
      rsp.scrolled   <= out_scr_next;
    end
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Cursor always points inside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_row) < ROWS) && (int'(cur_col) < COLS))
    else $error("cursor out of range");

  // A response is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!rsp.valid || rsp.ready))
    else $error("response register overwritten");

  // Scroll copy never reads the cell it writes in the same cycle
  a_scroll_ports: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("scroll read and write collide");

  // Scroll copy ends in the bottom-row fill
  a_scroll_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && ptr == AW'(SCROLL_LEN)) |=> (state == S_FILL && ptr == AW'(SCROLL_LEN)))
    else $error("scroll did not hand over to fill");

  // A clear starts its fill at the first cell with the cursor home
  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.op == OP_CLEAR) |=> (state == S_FILL && ptr == '0 && cur_row == '0))
    else $error("clear did not start at cell zero");

endmodule

>>> bench/tb_text_console_writer.sv
// Testbench for the text console writer: random and directed commands vs. a screen model.
module tb_text_console_writer import tcw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam op_t OP_UNUSED = 2'd3;
  // receiver hold-off used to back the block up into its command port
  localparam int HOLD_CYCLES = 300;
  // longest sweep of the block (scroll copy plus bottom fill) with margin
  localparam int SETTLE_CYCLES = CELLS + 2 * COLS;
  localparam int CYCLE_LIMIT = 20_000_000;

  // One response transfer
  typedef struct packed {
    cell_t      cell_value;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
  } console_rsp_t;

  // Screen buffer and cursor tracker plus the queue of responses still owed
  class console_scoreboard;
    cell_t        screen [CELLS];
    bit           screen_set [CELLS];
    int           cur_row;
    int           cur_col;
    logic [7:0]   attr;
    console_rsp_t owed_q [$];
    int           mismatches;

    function new();
      attr = ATTR_RESET;
      cur_row = 0;
      cur_col = 0;
      mismatches = 0;
      foreach (screen_set[i]) screen_set[i] = 1'b0;
    endfunction

    function void set_color(logic [7:0] value);
      attr = value;
    endfunction

    // Apply one accepted command and queue the response it owes
    function void note_cmd(op_t op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
      console_rsp_t e;
      e = '0;
      case (op)
        OP_PUT: begin
          if (ch == CH_NEWLINE) begin
            cur_col = COLS - 1;
          end else begin
            screen[cur_row * COLS + cur_col] = {attr, ch};
            screen_set[cur_row * COLS + cur_col] = 1'b1;
          end
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
              // rows move up; new bottom row is raw space with attribute 0
              cur_row = ROWS - 1;
              for (int i = 0; i < CELLS - COLS; i++) begin
                screen[i] = screen[i + COLS];
                screen_set[i] = screen_set[i + COLS];
              end
              for (int i = CELLS - COLS; i < CELLS; i++) begin
                screen[i] = {8'h00, CH_SPACE};
                screen_set[i] = 1'b1;
              end
              e.scrolled = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < CELLS; i++) begin
            screen[i] = {attr, CH_SPACE};
            screen_set[i] = 1'b1;
          end
          cur_row = 0;
          cur_col = 0;
        end
        OP_READ: begin
          if (rr < ROWS && rc < COLS) e.cell_value = screen[rr * COLS + rc];
        end
        default: ;
      endcase
      e.cursor_row = cur_row[4:0];
      e.cursor_col = cur_col[6:0];
      owed_q.push_back(e);
    endfunction

    function void report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    endfunction

    // Compare one response transfer against the oldest owed response
    function void check_rsp(console_rsp_t got);
      console_rsp_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with none owed, expected nothing actual %h", $time, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.cell_value !== want.cell_value)
        report_mismatch("cell_value", want.cell_value, got.cell_value);
      if (got.cursor_row !== want.cursor_row)
        report_mismatch("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
      if (got.cursor_col !== want.cursor_col)
        report_mismatch("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
      if (got.scrolled !== want.scrolled)
        report_mismatch("scrolled", 16'(want.scrolled), 16'(got.scrolled));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       text_color_we;
  logic [7:0] text_color_wdata;

  tcw_cmd_if cmd ();
  tcw_rsp_if rsp ();

  console_scoreboard board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .text_color_we(text_color_we),
    .text_color_wdata(text_color_wdata),
    .cmd(cmd),
    .rsp(rsp)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Response side: check each transfer, then pick ready for the next cycle
  initial begin : response_side
    int hold_left;
    console_rsp_t got;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got = {rsp.cell_value, rsp.cursor_row, rsp.cursor_col, rsp.scrolled};
        board.check_rsp(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one command and hold it until the transfer; valid stays high after
  task automatic send_cmd(input op_t op, input logic [7:0] ch,
                          input logic [4:0] rr, input logic [6:0] rc);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op <= op;
    cmd.char_code <= ch;
    cmd.read_row <= rr;
    cmd.read_col <= rc;
    do @(posedge clk); while (!cmd.ready);
    board.note_cmd(op, ch, rr, rc);
  endtask

  // Stop offering and wait until every owed response has come back
  task automatic drain();
    cmd.valid <= 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] value);
    text_color_we <= 1'b1;
    text_color_wdata <= value;
    @(posedge clk);
    text_color_we <= 1'b0;
    board.set_color(value);
  endtask

  // One random phase: new color, idle and stall mix, optional receiver hold-off
  task automatic run_phase(input int idle_pct, input int stall, input logic [7:0] color,
                           input bit hold, input int count);
    int n;
    int pick;
    logic [4:0] rr;
    logic [6:0] rc;
    drain();
    write_color(color);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    hold_request = hold;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(999);
      if (pick < 12) begin
        // run of line feeds walks the cursor off the bottom row
        repeat (ROWS + 2) send_cmd(OP_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
        n += ROWS + 2;
      end else if (pick < 500) begin
        send_cmd(OP_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
        n++;
      end else if (pick < 680) begin
        send_cmd(OP_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
        n++;
      end else if (pick < 930) begin
        rr = 5'($urandom_range(ROWS - 1));
        rc = 7'($urandom_range(COLS - 1));
        case ($urandom_range(9))
          0: rr = 5'($urandom_range(31, ROWS));
          1: rc = 7'($urandom_range(127, COLS));
          2, 3: rr = 5'(ROWS - 1);
          default: ;
        endcase
        // never touch a cell that nothing has written yet
        if (rr < ROWS && rc < COLS && !board.screen_set[rr * COLS + rc]) rr = 5'd31;
        send_cmd(OP_READ, 8'($urandom), rr, rc);
        n++;
      end else if (pick < 965) begin
        send_cmd(OP_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        n++;
      end else if (pick < 972) begin
        send_cmd(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        n++;
      end else begin
        send_cmd(OP_PUT, 8'($urandom_range(127, 32)), 5'($urandom), 7'($urandom));
        n++;
      end
      if ($urandom_range(149) == 0) drain();
    end
  endtask

  // Command side: reset, directed cases, random phases, wind-down
  initial begin : command_side
    rst <= 1'b1;
    text_color_we <= 1'b0;
    text_color_wdata <= '0;
    cmd.valid <= 1'b0;
    cmd.op <= OP_PUT;
    cmd.char_code <= '0;
    cmd.read_row <= '0;
    cmd.read_col <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // put before any clear, then read back only that cell
    send_cmd(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
    // reads off the screen
    send_cmd(OP_READ, 8'hFF, 5'(ROWS), 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'(COLS));
    send_cmd(OP_READ, 8'h00, 5'd31, 7'd127);
    // unused op
    send_cmd(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
    send_cmd(OP_UNUSED, 8'h00, 5'd0, 7'd0);
    // clear in reset color, far corner
    send_cmd(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1));
    // high characters
    send_cmd(OP_PUT, 8'hFF, 5'd31, 7'd127);
    send_cmd(OP_PUT, 8'h80, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd1);
    send_cmd(OP_PUT, CH_NEWLINE, 5'd31, 7'd127);
    // attribute extremes
    drain();
    write_color(8'hFF);
    send_cmd(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd1, 7'd0);
    drain();
    write_color(8'h00);
    send_cmd(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_cmd(OP_READ, 8'h00, 5'd12, 7'd40);
    send_cmd(OP_PUT, 8'h7F, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);

    run_phase(0, 0, 8'($urandom), 1'b0, 200);
    run_phase(84, 0, 8'h0F, 1'b0, 200);
    run_phase(0, 84, 8'hF0, 1'b0, 200);
    run_phase(27, 27, 8'($urandom), 1'b0, 200);
    // receiver backs off while commands keep coming
    run_phase(0, 0, 8'($urandom), 1'b1, 60);

    stall_pct = 0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.owed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
